### rtl/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg
// Types, codes and constants shared by the RPC frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package rfd_pkg;

  typedef enum logic [5:0] {
    PhSig  = 6'b000001,
    PhSize = 6'b000010,
    PhNlen = 6'b000100,
    PhName = 6'b001000,
    PhMeth = 6'b010000,
    PhPay  = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    KindNone = 2'd0,
    KindName = 2'd1,
    KindMeth = 2'd2,
    KindPay  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StShort    = 3'd1,
    StBadSig   = 3'd2,
    StSizeErr  = 3'd3,
    StTrunc    = 3'd4
  } status_t;

  localparam logic [31:0] HdrBytes = 32'd11;
  localparam logic [1:0]  SigLastIdx = 2'd2;

  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h5A;
      2'd1:    b = 8'h65;
      2'd2:    b = 8'h64;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [31:0] field_insert(input logic [31:0] acc,
                                               input logic [1:0]  idx,
                                               input logic [7:0]  b);
    logic [31:0] r;
    r = acc;
    case (idx)
      2'd0:    r[7:0]   = acc[7:0]   | b;
      2'd1:    r[15:8]  = acc[15:8]  | b;
      2'd2:    r[23:16] = acc[23:16] | b;
      default: r[31:24] = acc[31:24] | b;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/rpc_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// rpc_frame_deframer_unit
// Splits a byte stream into service name bytes, method index and payload
// bytes, and reports the frame status on the last byte.
// ----------------------------------------------------------------------------
// Each accepted byte's result appears in the output register in the cycle after it is accepted.
// Throughput: one byte per cycle while in_ready is high; the frame state updates in the accept cycle.
// in_ready is high while the output register is empty or being drained.
// Reset (rst, synchronous): returns to the signature phase with counters and
// the kept error cleared, and empties the output register.
`default_nettype none

module rpc_frame_deframer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       item_kind,
  output logic [31:0]      item_value,
  output logic             frame_end,
  output logic [2:0]       frame_status
);

  rfd_pkg::phase_t phase, phase_next;
  logic [31:0] bytes_seen, bytes_seen_next;
  logic [1:0]  field_byte_index, field_byte_index_next;
  logic [31:0] declared_size, declared_size_next;
  logic [31:0] name_remaining, name_remaining_next;
  logic [31:0] field_accumulator, field_accumulator_next;
  logic [2:0]  error_code, error_code_next;

  logic [1:0]  kind_next;
  logic [31:0] value_next;
  logic [2:0]  status_next;
  logic [31:0] acc_ins;
  logic        past_nlen;
  logic        accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign past_nlen = (phase == rfd_pkg::PhNlen) || (phase == rfd_pkg::PhName) ||
                     (phase == rfd_pkg::PhMeth) || (phase == rfd_pkg::PhPay);
  assign acc_ins   = rfd_pkg::field_insert(field_accumulator, field_byte_index, data_byte);

  always_comb begin
    phase_next             = phase;
    field_byte_index_next  = field_byte_index;
    declared_size_next     = declared_size;
    name_remaining_next    = name_remaining;
    field_accumulator_next = field_accumulator;
    error_code_next        = error_code;
    kind_next              = rfd_pkg::KindNone;
    value_next             = 32'd0;
    status_next            = rfd_pkg::StOk;

    // flag overrun once the size is known
    if (error_code == rfd_pkg::StOk && past_nlen && bytes_seen >= declared_size) begin
      error_code_next = rfd_pkg::StSizeErr;
    end

    bytes_seen_next = (bytes_seen == '1) ? bytes_seen : bytes_seen + 32'd1;

    if (error_code_next == rfd_pkg::StOk) begin
      case (phase)
        rfd_pkg::PhSig: begin
          if (field_byte_index == 2'd3 ||
              data_byte != rfd_pkg::sig_byte(field_byte_index)) begin
            error_code_next = rfd_pkg::StBadSig;
          end else if (field_byte_index == rfd_pkg::SigLastIdx) begin
            field_byte_index_next  = 2'd0;
            field_accumulator_next = 32'd0;
            phase_next             = rfd_pkg::PhSize;
          end else begin
            field_byte_index_next = field_byte_index + 2'd1;
          end
        end
        rfd_pkg::PhSize: begin
          field_accumulator_next = acc_ins;
          field_byte_index_next  = field_byte_index + 2'd1;
          if (field_byte_index == 2'd3) begin
            declared_size_next     = acc_ins;
            field_accumulator_next = 32'd0;
            phase_next             = rfd_pkg::PhNlen;
          end
        end
        rfd_pkg::PhNlen: begin
          field_accumulator_next = acc_ins;
          field_byte_index_next  = field_byte_index + 2'd1;
          if (field_byte_index == 2'd3) begin
            name_remaining_next    = acc_ins;
            field_accumulator_next = 32'd0;
            phase_next = (acc_ins != 32'd0) ? rfd_pkg::PhName : rfd_pkg::PhMeth;
          end
        end
        rfd_pkg::PhName: begin
          kind_next           = rfd_pkg::KindName;
          value_next          = {24'd0, data_byte};
          name_remaining_next = name_remaining - 32'd1;
          if (name_remaining == 32'd1) begin
            phase_next = rfd_pkg::PhMeth;
          end
        end
        rfd_pkg::PhMeth: begin
          field_accumulator_next = acc_ins;
          field_byte_index_next  = field_byte_index + 2'd1;
          if (field_byte_index == 2'd3) begin
            kind_next              = rfd_pkg::KindMeth;
            value_next             = acc_ins;
            field_accumulator_next = 32'd0;
            phase_next             = rfd_pkg::PhPay;
          end
        end
        rfd_pkg::PhPay: begin
          kind_next  = rfd_pkg::KindPay;
          value_next = {24'd0, data_byte};
        end
        default: begin
          phase_next = rfd_pkg::PhSig;
        end
      endcase
    end

    if (last_byte) begin
      if (bytes_seen_next < rfd_pkg::HdrBytes) begin
        status_next = rfd_pkg::StShort;
      end else if (error_code_next != rfd_pkg::StOk) begin
        status_next = error_code_next;
      end else if (bytes_seen_next != declared_size_next) begin
        status_next = rfd_pkg::StSizeErr;
      end else if (phase_next != rfd_pkg::PhPay) begin
        status_next = rfd_pkg::StTrunc;
      end else begin
        status_next = rfd_pkg::StOk;
      end
      if (status_next != rfd_pkg::StOk) begin
        kind_next  = rfd_pkg::KindNone;
        value_next = 32'd0;
      end
      phase_next             = rfd_pkg::PhSig;
      bytes_seen_next        = 32'd0;
      field_byte_index_next  = 2'd0;
      declared_size_next     = 32'd0;
      name_remaining_next    = 32'd0;
      field_accumulator_next = 32'd0;
      error_code_next        = rfd_pkg::StOk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= rfd_pkg::PhSig;
      bytes_seen        <= 32'd0;
      field_byte_index  <= 2'd0;
      declared_size     <= 32'd0;
      name_remaining    <= 32'd0;
      field_accumulator <= 32'd0;
      error_code        <= rfd_pkg::StOk;
    end else if (accept) begin
      phase             <= phase_next;
      bytes_seen        <= bytes_seen_next;
      field_byte_index  <= field_byte_index_next;
      declared_size     <= declared_size_next;
      name_remaining    <= name_remaining_next;
      field_accumulator <= field_accumulator_next;
      error_code        <= error_code_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_kind    <= kind_next;
      item_value   <= value_next;
      frame_end    <= last_byte;
      frame_status <= status_next;
    end
  end

  a_status_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !frame_end) |-> (frame_status == rfd_pkg::StOk))
    else $error("status set on a result that does not close the frame");

  a_no_item_on_error: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end && frame_status != rfd_pkg::StOk) |->
    (item_kind == rfd_pkg::KindNone))
    else $error("item delivered with a failing frame status");

  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && item_kind == rfd_pkg::KindNone) |-> (item_value == 32'd0))
    else $error("empty result carries a value");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (accept && last_byte) |=>
    (phase == rfd_pkg::PhSig && bytes_seen == 32'd0 && error_code == rfd_pkg::StOk))
    else $error("frame state not cleared after last byte");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (error_code != rfd_pkg::StOk && !(accept && last_byte)) |=>
    (error_code == $past(error_code)))
    else $error("kept error changed within a frame");

endmodule

`default_nettype wire
